// ===== hw/rtl/c2d_pkg.sv =====
// Shared types and constants for the 3x3 stride-2 convolution engine.
package c2d_pkg;

    localparam logic [1:0] REQ_LOAD_ACT = 2'd0;
    localparam logic [1:0] REQ_LOAD_WGT = 2'd1;
    localparam logic [1:0] REQ_COMPUTE  = 2'd2;
    localparam logic [1:0] REQ_UNUSED   = 2'd3;

    localparam int KSIZE   = 3;
    localparam int KSTRIDE = 2;
    localparam int KPAD    = 1;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] index;
        logic [15:0] value;
        logic [3:0]  row;
        logic [3:0]  col;
    } c2d_cmd_t;

endpackage

// ===== hw/rtl/conv2d_3x3_stride2_engine.sv =====
// A compute is accepted only by an idle engine and yields one sum per output channel.
// Each output channel's sum is posted once the last result beat has been taken;
// one shared multiplier walks the taps, with one read of each store per tap.
// Loads are written while the back part is idle; a four-entry queue decouples acceptance.
// Reset: rst_n asynchronous, clears control; stores are undefined until loaded.
module conv2d_3x3_stride2_engine #(
    parameter int IN_CHANNELS  = 3,
    parameter int OUT_CHANNELS = 64,
    parameter int IN_HEIGHT    = 32,
    parameter int IN_WIDTH     = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic [11:0]        load_index,
    input  logic signed [15:0] load_value,
    input  logic [3:0]         out_row,
    input  logic [3:0]         out_col,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [5:0]         result_channel,
    output logic [3:0]         result_row,
    output logic [3:0]         result_col,
    output logic signed [39:0] result_value,
    output logic               last_of_run
);
    import c2d_pkg::*;

    logic     cmd_valid, cmd_ready;
    c2d_cmd_t cmd;

    c2d_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .req_type, .load_index,
        .load_value, .out_row, .out_col, .cmd_valid, .cmd_ready, .cmd
    );

    c2d_back #(
        .IN_CHANNELS(IN_CHANNELS), .OUT_CHANNELS(OUT_CHANNELS),
        .IN_HEIGHT(IN_HEIGHT), .IN_WIDTH(IN_WIDTH)
    ) u_back (
        .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd, .out_valid, .out_ready,
        .result_channel, .result_row, .result_col, .result_value, .last_of_run
    );
endmodule

// ===== hw/rtl/c2d_front.sv =====
// Front part: accepts items, drops unused codes, queues commands for the back part.
module c2d_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        req_type,
    input  logic [11:0]       load_index,
    input  logic signed [15:0] load_value,
    input  logic [3:0]        out_row,
    input  logic [3:0]        out_col,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output c2d_pkg::c2d_cmd_t cmd
);
    import c2d_pkg::*;

    localparam int DEPTH = 4;

    c2d_cmd_t   q_reg [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       push, pop, keep;

    assign in_ready  = (count_reg != 3'(DEPTH));
    assign keep      = (req_type != REQ_UNUSED);
    assign push      = in_valid && in_ready && keep;
    assign cmd_valid = (count_reg != 3'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + {2'd0, push} - {2'd0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{kind: req_type, index: load_index,
                                   value: load_value, row: out_row, col: out_col};
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(DEPTH)) else $error("queue count overflow");
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 3'(DEPTH) |-> !push) else $error("push into full queue");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 3'd1)
        else $error("count did not advance on push");
`endif
endmodule

// ===== hw/rtl/c2d_back.sv =====
// Back part: stores, tap sequencer, multiply-accumulate and result register.
module c2d_back #(
    parameter int IN_CHANNELS  = 3,
    parameter int OUT_CHANNELS = 64,
    parameter int IN_HEIGHT    = 32,
    parameter int IN_WIDTH     = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  c2d_pkg::c2d_cmd_t cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [5:0]        result_channel,
    output logic [3:0]        result_row,
    output logic [3:0]        result_col,
    output logic signed [39:0] result_value,
    output logic              last_of_run
);
    import c2d_pkg::*;

    localparam int IN_DEPTH = IN_CHANNELS * IN_HEIGHT * IN_WIDTH;
    localparam int W_DEPTH  = OUT_CHANNELS * IN_CHANNELS * 9;
    localparam int IA_W     = $clog2(IN_DEPTH);
    localparam int WA_W     = $clog2(W_DEPTH);
    localparam int IC_W     = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
    localparam int OC_W     = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
    localparam int PLANE    = IN_HEIGHT * IN_WIDTH;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic signed [15:0] act_mem [IN_DEPTH];
    logic signed [15:0] wgt_mem [W_DEPTH];

    logic [1:0]      state_reg, state_next;
    logic [OC_W-1:0] oc_reg;
    logic [IC_W-1:0] ic_reg;
    logic [1:0]      ky_reg, kx_reg;
    logic [3:0]      row_reg, col_reg;
    logic            last_tap;

    // Pipeline: address -> memory read -> product -> accumulate.
    logic               p1_valid_reg, p1_zero_reg;
    logic               p2_valid_reg;
    logic signed [15:0] act_rd_reg, wgt_rd_reg;
    logic signed [31:0] prod_reg;
    logic signed [39:0] acc_reg;
    logic               out_valid_reg;
    logic [5:0]         ch_out_reg;
    logic [3:0]         row_out_reg, col_out_reg;
    logic               last_out_reg;
    logic signed [39:0] val_out_reg;

    logic signed [10:0] iy, ix;
    logic               in_img;
    logic [IA_W-1:0]    ia;
    logic [WA_W-1:0]    wa;
    logic               tap_go;

    assign tap_go   = (state_reg == ST_RUN);
    assign last_tap = (ic_reg == IC_W'(IN_CHANNELS - 1)) && (ky_reg == 2'd2) && (kx_reg == 2'd2);

    always_comb
    begin
        iy = 11'(signed'({1'b0, row_reg, 1'b0})) + 11'(signed'({1'b0, ky_reg})) - 11'sd1;
        ix = 11'(signed'({1'b0, col_reg, 1'b0})) + 11'(signed'({1'b0, kx_reg})) - 11'sd1;
        in_img = (iy >= 0) && (iy < 11'(IN_HEIGHT)) && (ix >= 0) && (ix < 11'(IN_WIDTH));
        ia = IA_W'(32'(ic_reg) * PLANE + 32'(iy[9:0]) * IN_WIDTH + 32'(ix[9:0]));
        wa = WA_W'(((32'(oc_reg) * IN_CHANNELS + 32'(ic_reg)) * 3 + 32'(ky_reg)) * 3
                   + 32'(kx_reg));
    end

    assign cmd_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (cmd_valid && cmd.kind == REQ_COMPUTE) state_next = ST_RUN;
            ST_RUN:  if (last_tap) state_next = ST_SUM;
            // wait for the pipe to drain into the accumulator and the last result beat to be taken
            ST_SUM:  if (!p1_valid_reg && !p2_valid_reg && !out_valid_reg) state_next = ST_OUT;
            ST_OUT:  state_next = (oc_reg == OC_W'(OUT_CHANNELS - 1)) ? ST_IDLE : ST_RUN;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            oc_reg        <= '0;
            ic_reg        <= '0;
            ky_reg        <= '0;
            kx_reg        <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            p1_valid_reg <= tap_go;
            p2_valid_reg <= p1_valid_reg;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_SUM && state_next == ST_OUT)
                out_valid_reg <= 1'b1;
            if (state_reg == ST_IDLE)
            begin
                oc_reg <= '0;
                ic_reg <= '0;
                ky_reg <= '0;
                kx_reg <= '0;
            end
            else if (tap_go)
            begin
                if (kx_reg == 2'd2)
                begin
                    kx_reg <= '0;
                    if (ky_reg == 2'd2)
                    begin
                        ky_reg <= '0;
                        ic_reg <= last_tap ? '0 : ic_reg + IC_W'(1);
                    end
                    else
                        ky_reg <= ky_reg + 2'd1;
                end
                else
                    kx_reg <= kx_reg + 2'd1;
            end
            else if (state_reg == ST_OUT && state_next == ST_RUN)
                oc_reg <= oc_reg + OC_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            if (cmd.kind == REQ_LOAD_ACT && 32'(cmd.index) < IN_DEPTH)
                act_mem[IA_W'(cmd.index)] <= cmd.value;
            if (cmd.kind == REQ_LOAD_WGT && 32'(cmd.index) < W_DEPTH)
                wgt_mem[WA_W'(cmd.index)] <= cmd.value;
            row_reg <= cmd.row;
            col_reg <= cmd.col;
        end
        act_rd_reg  <= act_mem[ia];
        wgt_rd_reg  <= wgt_mem[wa];
        p1_zero_reg <= !in_img;
        prod_reg    <= p1_zero_reg ? 32'sd0 : act_rd_reg * wgt_rd_reg;
        if (state_reg == ST_OUT)
            acc_reg <= '0;
        else if (state_reg == ST_IDLE)
            acc_reg <= '0;
        else if (p2_valid_reg)
            acc_reg <= acc_reg + 40'(prod_reg);
        // hold the position with the sum so a new command cannot disturb a waiting beat
        if (state_reg == ST_SUM && state_next == ST_OUT)
        begin
            val_out_reg  <= acc_reg;
            ch_out_reg   <= 6'(oc_reg);
            row_out_reg  <= row_reg;
            col_out_reg  <= col_reg;
            last_out_reg <= (oc_reg == OC_W'(OUT_CHANNELS - 1));
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_channel = ch_out_reg;
    assign result_row     = row_out_reg;
    assign result_col     = col_out_reg;
    assign result_value   = val_out_reg;
    assign last_of_run    = last_out_reg;

`ifndef SYNTH
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value))
        else $error("result dropped while stalled");
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> !p1_valid_reg || state_reg != ST_IDLE || !tap_go)
        else $error("taps issued while idle");
    a_sum_wait: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT |-> out_valid_reg)
        else $error("sum state without result");
`endif
endmodule

// ===== sim/conv2d_3x3_stride2_engine_tb.sv =====
// Self-checking testbench for the 3x3 stride-2 convolution engine.
`timescale 1ns / 100ps

module conv2d_3x3_stride2_engine_tb;
    import c2d_pkg::*;

    localparam int IN_CH   = 3;
    localparam int OUT_CH  = 64;
    localparam int IN_H    = 32;
    localparam int IN_W    = 32;
    localparam int ACT_DEPTH = IN_CH * IN_H * IN_W;
    localparam int WGT_DEPTH = OUT_CH * IN_CH * KSIZE * KSIZE;

    typedef struct {
        logic [5:0]         channel;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [39:0] value;
        logic               last;
    } channel_sum_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         req_type;
    logic [11:0]        load_index;
    logic signed [15:0] load_value;
    logic [3:0]         out_row;
    logic [3:0]         out_col;
    logic               out_valid;
    logic               out_ready;
    logic [5:0]         result_channel;
    logic [3:0]         result_row;
    logic [3:0]         result_col;
    logic signed [39:0] result_value;
    logic               last_of_run;

    logic signed [15:0] act_mem [ACT_DEPTH];
    logic signed [15:0] wgt_mem [WGT_DEPTH];
    channel_sum_t       pending_sums [$];

    int  errors;
    int  sums_checked;
    int  computes_sent;
    int  loads_sent;
    bit  idle_on;
    int  hold_req;
    int  hold_left;
    int  stall_left;

    conv2d_3x3_stride2_engine u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .load_index     (load_index),
        .load_value     (load_value),
        .out_row        (out_row),
        .out_col        (out_col),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_channel (result_channel),
        .result_row     (result_row),
        .result_col     (result_col),
        .result_value   (result_value),
        .last_of_run    (last_of_run)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic signed [39:0] conv_sum(input int oc, input int r, input int c);
        longint acc;
        int     iy;
        int     ix;
        acc = 0;
        for (int ic = 0; ic < IN_CH; ic++)
        begin
            for (int ky = 0; ky < KSIZE; ky++)
            begin
                for (int kx = 0; kx < KSIZE; kx++)
                begin
                    iy = r * KSTRIDE + ky - KPAD;
                    ix = c * KSTRIDE + kx - KPAD;
                    // padding taps add nothing
                    if (iy >= 0 && iy < IN_H && ix >= 0 && ix < IN_W)
                        acc += longint'(act_mem[ic * IN_H * IN_W + iy * IN_W + ix])
                             * longint'(wgt_mem[((oc * IN_CH + ic) * KSIZE + ky) * KSIZE + kx]);
                end
            end
        end
        return acc[39:0];
    endfunction

    function automatic void apply_beat(input logic [1:0] kind, input logic [11:0] idx,
                                       input logic signed [15:0] val,
                                       input logic [3:0] r, input logic [3:0] c);
        channel_sum_t s;
        if (kind == REQ_LOAD_ACT)
        begin
            loads_sent++;
            if (int'(idx) < ACT_DEPTH)
                act_mem[idx] = val;
        end
        else if (kind == REQ_LOAD_WGT)
        begin
            loads_sent++;
            if (int'(idx) < WGT_DEPTH)
                wgt_mem[idx] = val;
        end
        else if (kind == REQ_COMPUTE)
        begin
            computes_sent++;
            for (int oc = 0; oc < OUT_CH; oc++)
            begin
                s.channel = oc[5:0];
                s.row     = r;
                s.col     = c;
                s.value   = conv_sum(oc, int'(r), int'(c));
                s.last    = (oc == OUT_CH - 1);
                pending_sums.push_back(s);
            end
        end
    endfunction

    task automatic send_beat(input logic [1:0] kind, input logic [11:0] idx,
                             input logic signed [15:0] val,
                             input logic [3:0] r, input logic [3:0] c);
        int gap;
        @(negedge clk);
        in_valid   <= 1'b1;
        req_type   <= kind;
        load_index <= idx;
        load_value <= val;
        out_row    <= r;
        out_col    <= c;
        do
            @(posedge clk);
        while (!in_ready);
        apply_beat(kind, idx, val, r, c);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 18);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_compute(input logic [3:0] r, input logic [3:0] c);
        send_beat(REQ_COMPUTE, 12'($urandom), 16'($urandom), r, c);
    endtask

    // Fill both stores so no compute ever touches an unwritten entry.
    task automatic test_preload();
        for (int i = 0; i < WGT_DEPTH; i++)
            send_beat(REQ_LOAD_WGT, i[11:0], 16'($urandom), 4'($urandom), 4'($urandom));
        for (int i = 0; i < ACT_DEPTH; i++)
            send_beat(REQ_LOAD_ACT, i[11:0], 16'($urandom), 4'($urandom), 4'($urandom));
    endtask

    task automatic test_directed();
        // extreme values on a corner tap and its weights
        send_beat(REQ_LOAD_ACT, 12'd0, 16'sh8000, 4'd0, 4'd0);
        send_beat(REQ_LOAD_ACT, 12'd1, 16'sh7fff, 4'd0, 4'd0);
        send_beat(REQ_LOAD_WGT, 12'd4, 16'sh8000, 4'd0, 4'd0);
        send_beat(REQ_LOAD_WGT, 12'd5, 16'sh7fff, 4'd0, 4'd0);
        send_beat(REQ_LOAD_ACT, 12'(ACT_DEPTH - 1), 16'sh8000, 4'd15, 4'd15);
        send_beat(REQ_LOAD_WGT, 12'(WGT_DEPTH - 1), 16'sh8000, 4'd15, 4'd15);
        // writes past the end of each store are dropped
        send_beat(REQ_LOAD_ACT, 12'hfff, 16'sh1234, 4'd0, 4'd0);
        send_beat(REQ_LOAD_ACT, 12'(ACT_DEPTH), 16'sh4321, 4'd0, 4'd0);
        send_beat(REQ_LOAD_WGT, 12'(WGT_DEPTH), 16'sh5555, 4'd0, 4'd0);
        send_beat(REQ_LOAD_WGT, 12'hfff, 16'shaaaa, 4'd0, 4'd0);
        // unused request type does nothing
        send_beat(REQ_UNUSED, 12'd0, 16'sh7fff, 4'd15, 4'd15);
        send_compute(4'd0, 4'd0);
        send_compute(4'd15, 4'd15);
        send_compute(4'd0, 4'd15);
        send_compute(4'd15, 4'd0);
        send_compute(4'd7, 4'd8);
        wait_drained();
    endtask

    task automatic test_random(input int n_items);
        int pick;
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_beat(REQ_LOAD_ACT,
                          12'((pick < 3) ? $urandom : $urandom_range(0, ACT_DEPTH - 1)),
                          16'($urandom), 4'($urandom), 4'($urandom));
            else if (pick < 75)
                send_beat(REQ_LOAD_WGT,
                          12'((pick < 57) ? $urandom : $urandom_range(0, WGT_DEPTH - 1)),
                          16'($urandom), 4'($urandom), 4'($urandom));
            else if (pick < 95)
                send_compute(4'($urandom), 4'($urandom));
            else
                send_beat(REQ_UNUSED, 12'($urandom), 16'($urandom), 4'($urandom),
                          4'($urandom));
        end
    endtask

    // Hold results off long enough that the input queue fills and stalls.
    task automatic test_backpressure();
        hold_req = 600;
        for (int i = 0; i < 6; i++)
            send_compute(4'($urandom), 4'($urandom));
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 17);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        channel_sum_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_sums.size() == 0)
            begin
                $error("unexpected result beat: channel %0d", result_channel);
                errors++;
            end
            else
            begin
                want = pending_sums.pop_front();
                sums_checked++;
                if (result_channel !== want.channel)
                begin
                    $error("result_channel: expected %0d, got %0d", want.channel, result_channel);
                    errors++;
                end
                if (result_row !== want.row)
                begin
                    $error("result_row: expected %0d, got %0d", want.row, result_row);
                    errors++;
                end
                if (result_col !== want.col)
                begin
                    $error("result_col: expected %0d, got %0d", want.col, result_col);
                    errors++;
                end
                if (result_value !== want.value)
                begin
                    $error("result_value: expected %0d, got %0d", want.value, result_value);
                    errors++;
                end
                if (last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20000000;
        $display("conv2d_3x3_stride2_engine_tb failed");
        $finish;
    end

    initial
    begin
        errors        = 0;
        sums_checked  = 0;
        computes_sent = 0;
        loads_sent    = 0;
        hold_req      = 0;
        hold_left     = 0;
        stall_left    = 0;
        idle_on       = 1'b1;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        out_ready     = 1'b0;
        req_type      = REQ_LOAD_ACT;
        load_index    = '0;
        load_value    = '0;
        out_row       = '0;
        out_col       = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_preload();
        test_directed();
        test_backpressure();
        test_random(300);
        wait_drained();
        idle_on = 1'b0;
        test_random(100);
        wait_drained();
        repeat (200) @(posedge clk);

        $display("covered %0d loads and %0d computes, %0d channel sums checked",
                 loads_sent, computes_sent, sums_checked);
        $display("with corner, padded and extreme taps, dropped writes and output stalls");
        if (errors == 0 && pending_sums.size() == 0)
            $display("conv2d_3x3_stride2_engine_tb passed");
        else
            $display("conv2d_3x3_stride2_engine_tb failed");
        $finish;
    end

endmodule
